// ===== rtl/core/whcp_pkg.sv =====
// Package for the WAV header chunk parser: phase and status codes, chunk ids,
// the item and result types shared by the parser modules.
// No dependencies.
`default_nettype none

package whcp_pkg;

  // Width of byte lengths and offsets; the position counter is one bit wider and saturates at 2^LENGTH_BITS.
  localparam int LENGTH_BITS = 32;
  localparam int POS_W       = LENGTH_BITS + 1;

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_PAD  = 3'd3;
  localparam logic [2:0] PH_IDLE = 3'd4;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NOT_WAVE    = 2'd1;
  localparam logic [1:0] STATUS_MISSING     = 2'd2;
  localparam logic [1:0] STATUS_NOT_PCM     = 2'd3;

  localparam logic [31:0] ID_FMT       = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA      = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } whcp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] format_code;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_width;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } whcp_result_t;

  // Expected magic byte: "RIFF" at bytes 0..3, "WAVE" at bytes 8..11.
  function automatic logic [7:0] magic_byte(input logic wave, input logic [1:0] idx);
    logic [7:0] val;
    val = 8'h00;
    unique case ({wave, idx})
      3'b000:  val = 8'h52;
      3'b001:  val = 8'h49;
      3'b010:  val = 8'h46;
      3'b011:  val = 8'h46;
      3'b100:  val = 8'h57;
      3'b101:  val = 8'h41;
      3'b110:  val = 8'h56;
      default: val = 8'h45;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/whcp_in_reg.sv =====
// Input register stage of the WAV header chunk parser.
// Holds one accepted byte until the parse stage consumes it. Uses whcp_pkg.
`default_nettype none

module whcp_in_reg
  import whcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire whcp_item_t in_item,
  input  wire logic       take,
  output logic            item_valid,
  output whcp_item_t      item
);

  logic       valid_r;
  whcp_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/whcp_parse.sv =====
// Parse stage of the WAV header chunk parser: magic check, chunk header walk,
// field capture and the result on the last byte. Uses whcp_pkg.
`default_nettype none

module whcp_parse
  import whcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire whcp_item_t item,
  input  wire logic       out_blocked,
  output logic            take,
  output logic            res_valid,
  output whcp_result_t    res
);

  logic [POS_W-1:0] pos_r;
  logic [2:0]       phase_r, phase_nxt;
  logic             magic_bad_r, magic_bad_nxt;
  logic [63:0]      hdr_r, hdr_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic             pad_r, pad_nxt;
  logic [63:0]      pend_r, pend_nxt;
  logic [15:0]      pend_bits_r, pend_bits_nxt;
  logic             have_fmt_r, have_fmt_nxt;
  logic             have_data_r, have_data_nxt;
  logic [63:0]      fmt_word_r, fmt_word_nxt;
  logic [15:0]      bits_word_r, bits_word_nxt;
  logic [31:0]      data_start_r, data_start_nxt;
  logic [31:0]      data_size_r, data_size_nxt;
  logic [POS_W-1:0] pos_nxt;

  logic [7:0]             b;
  logic                   magic_ok;
  logic                   finish;
  logic [31:0]            size;
  logic [31:0]            off;
  logic [LENGTH_BITS-1:0] start_sat;

  // The last byte waits here while the previous result is still unread.
  assign take      = item_valid && !(item.last && out_blocked);
  assign res_valid = take && item.last;
  assign b         = item.data_byte;
  assign size      = {b, hdr_r[63:40]};
  assign off       = len_r - rem_r;
  assign start_sat = (pos_r[POS_W-1] || (&pos_r[LENGTH_BITS-1:0])) ?
                     {LENGTH_BITS{1'b1}} : (pos_r[LENGTH_BITS-1:0] + 1'b1);

  always_comb begin
    magic_ok = 1'b1;
    if (pos_r < POS_W'(4)) begin
      magic_ok = (b == magic_byte(1'b0, pos_r[1:0]));
    end else if (pos_r >= POS_W'(8) && pos_r < POS_W'(12)) begin
      magic_ok = (b == magic_byte(1'b1, pos_r[1:0]));
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    magic_bad_nxt  = magic_bad_r;
    hdr_nxt        = hdr_r;
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    rem_nxt        = rem_r;
    pad_nxt        = pad_r;
    pend_nxt       = pend_r;
    pend_bits_nxt  = pend_bits_r;
    have_fmt_nxt   = have_fmt_r;
    have_data_nxt  = have_data_r;
    fmt_word_nxt   = fmt_word_r;
    bits_word_nxt  = bits_word_r;
    data_start_nxt = data_start_r;
    data_size_nxt  = data_size_r;
    finish         = 1'b0;
    pos_nxt        = pos_r[POS_W-1] ? pos_r : pos_r + 1'b1;

    unique case (phase_r)
      PH_RIFF: begin
        if (!magic_ok) begin
          magic_bad_nxt = 1'b1;
          phase_nxt     = PH_IDLE;
        end else if (pos_r >= POS_W'(11)) begin
          phase_nxt = PH_HEAD;
          rem_nxt   = '0;
        end
      end
      PH_HEAD: begin
        hdr_nxt = {b, hdr_r[63:8]};
        rem_nxt = rem_r + 1'b1;
        // The eighth header byte completes id and size.
        if (rem_r == 32'd7) begin
          len_nxt       = size;
          pend_nxt      = '0;
          pend_bits_nxt = '0;
          if (hdr_r[39:8] == ID_FMT && size >= FMT_MIN_SIZE) begin
            kind_nxt = KIND_FMT;
          end else if (hdr_r[39:8] == ID_DATA) begin
            kind_nxt = KIND_DATA;
            pend_nxt = 64'(start_sat);
          end else begin
            kind_nxt = KIND_OTHER;
          end
          pad_nxt = size[0];
          rem_nxt = size;
          if (size == '0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (kind_r == KIND_FMT) begin
          if (off < 32'd8) begin
            pend_nxt[{off[2:0], 3'b000} +: 8] = b;
          end else if (off == 32'd14) begin
            pend_bits_nxt[7:0] = b;
          end else if (off == 32'd15) begin
            pend_bits_nxt[15:8] = b;
          end
        end
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 32'd1) begin
          finish = 1'b1;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_HEAD;
        rem_nxt   = '0;
      end
      default: begin
      end
    endcase

    if (finish) begin
      if (kind_nxt == KIND_FMT) begin
        fmt_word_nxt  = pend_nxt;
        bits_word_nxt = pend_bits_nxt;
        have_fmt_nxt  = 1'b1;
      end else if (kind_nxt == KIND_DATA) begin
        data_start_nxt = pend_nxt[31:0];
        data_size_nxt  = len_nxt;
        have_data_nxt  = 1'b1;
      end
      phase_nxt = pad_nxt ? PH_PAD : PH_HEAD;
      rem_nxt   = '0;
    end
  end

  always_comb begin
    if (magic_bad_nxt || phase_nxt == PH_RIFF) begin
      res.status = STATUS_NOT_WAVE;
    end else if (!have_fmt_nxt || !have_data_nxt) begin
      res.status = STATUS_MISSING;
    end else if (fmt_word_nxt[15:0] != FORMAT_PCM) begin
      res.status = STATUS_NOT_PCM;
    end else begin
      res.status = STATUS_OK;
    end
    res.format_code  = fmt_word_nxt[15:0];
    res.channels     = fmt_word_nxt[31:16];
    res.rate_hz      = fmt_word_nxt[63:32];
    res.sample_width = bits_word_nxt;
    res.data_offset  = data_start_nxt;
    res.data_length  = data_size_nxt;
  end

  // After the last byte of a file everything returns to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pos_r        <= '0;
      phase_r      <= PH_RIFF;
      magic_bad_r  <= 1'b0;
      hdr_r        <= '0;
      kind_r       <= KIND_OTHER;
      len_r        <= '0;
      rem_r        <= '0;
      pad_r        <= 1'b0;
      pend_r       <= '0;
      pend_bits_r  <= '0;
      have_fmt_r   <= 1'b0;
      have_data_r  <= 1'b0;
      fmt_word_r   <= '0;
      bits_word_r  <= '0;
      data_start_r <= '0;
      data_size_r  <= '0;
    end else if (take) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      magic_bad_r  <= magic_bad_nxt;
      hdr_r        <= hdr_nxt;
      kind_r       <= kind_nxt;
      len_r        <= len_nxt;
      rem_r        <= rem_nxt;
      pad_r        <= pad_nxt;
      pend_r       <= pend_nxt;
      pend_bits_r  <= pend_bits_nxt;
      have_fmt_r   <= have_fmt_nxt;
      have_data_r  <= have_data_nxt;
      fmt_word_r   <= fmt_word_nxt;
      bits_word_r  <= bits_word_nxt;
      data_start_r <= data_start_nxt;
      data_size_r  <= data_size_nxt;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_RIFF && pos_r == '0 && !have_fmt_r && !have_data_r))
    else $error("parser did not restart after the last byte");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (rem_r != '0 && rem_r <= len_r))
    else $error("chunk body with no remaining bytes");

  a_bad_magic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    magic_bad_r |-> (phase_r == PH_IDLE && !have_fmt_r && !have_data_r))
    else $error("bad magic but parsing continued");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (rem_r < 32'd8))
    else $error("chunk header count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/whcp_out_reg.sv =====
// Result register of the WAV header chunk parser.
// Holds one result until the consumer takes it. Uses whcp_pkg.
`default_nettype none

module whcp_out_reg
  import whcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_valid,
  input  wire whcp_result_t res,
  output logic              out_blocked,
  output logic              out_valid,
  input  wire logic         out_ready,
  output whcp_result_t      out_res
);

  logic         valid_r;
  whcp_result_t res_r;

  assign out_valid   = valid_r;
  assign out_res     = res_r;
  assign out_blocked = valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wav_header_chunk_parser.sv =====
// Top level of the WAV header chunk parser: input register, parse stage and
// result register. Uses whcp_pkg, whcp_in_reg, whcp_parse and whcp_out_reg.
//
//   Channel  Ports            Payload
//   in       in_t*            tdata[7:0] file byte, tlast final byte of the file
//   out      out_t*           tuser status, tdata the header fields (one per file)
//
// One byte is taken every cycle unless a last byte stalls. Each byte is parsed
// from the input register, and the result of a file is registered in the
// result register when its last byte is parsed. Only the last byte of a file can
// stall, while the previous result is still unread. Reset is synchronous and
// active low, and the parser also returns to its reset state after every file.
`default_nettype none

module wav_header_chunk_parser
  import whcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,  // [15:0] format_code, [31:16] channels,
                                        // [63:32] rate_hz, [79:64] sample_width,
                                        // [111:80] data_offset, [143:112] data_length
  output logic [1:0]        out_tuser   // [1:0] status
);

  whcp_item_t   in_item;
  whcp_item_t   item;
  logic         item_valid;
  logic         take;
  logic         res_valid;
  logic         out_blocked;
  whcp_result_t res;
  whcp_result_t out_res;

  assign in_item.data_byte = in_tdata;
  assign in_item.last      = in_tlast;

  whcp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  whcp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .out_blocked (out_blocked),
    .take        (take),
    .res_valid   (res_valid),
    .res         (res)
  );

  whcp_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res         (res),
    .out_blocked (out_blocked),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {out_res.data_length, out_res.data_offset, out_res.sample_width,
                      out_res.rate_hz, out_res.channels, out_res.format_code};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for wav_header_chunk_parser: WAV file bytes in, header reports out.
// Needs whcp_pkg and the parser RTL; a built-in header predictor supplies the expected reports.
`timescale 1ns / 1ps

module tb_top
  import whcp_pkg::*;
();

  localparam logic [31:0] RIFF_TAG = "RIFF";
  localparam logic [31:0] WAVE_TAG = "WAVE";
  localparam logic [32:0] POS_CAP  = 33'd1 << LENGTH_BITS;
  localparam logic [32:0] POS_MAX  = POS_CAP - 33'd1;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] data_byte
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;  // [15:0] format_code, [31:16] channels, [63:32] rate_hz,
                            // [79:64] sample_width, [111:80] data_offset,
                            // [143:112] data_length
  logic [1:0]   out_tuser;  // [1:0] status

  wav_header_chunk_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  whcp_result_t expected_headers[$];
  logic [7:0]   file_bytes[$];
  int           error_count = 0;
  int           bytes_sent = 0;
  bit           idle_on = 0;
  bit           src_idle = 0;
  bit           sink_idle = 0;
  bit           sink_hold = 0;

  // Header predictor state.
  logic [32:0] hdr_pos;
  logic [2:0]  hdr_phase;
  bit          magic_failed;
  logic [63:0] hdr_shift;
  logic [1:0]  cur_kind;
  logic [31:0] cur_len;
  logic [32:0] cur_left;
  bit          cur_pad;
  logic [63:0] cur_fields;
  logic [15:0] cur_bits;
  bit          fmt_seen;
  bit          data_seen;
  logic [63:0] fmt_word;
  logic [15:0] fmt_bits;
  logic [31:0] data_start;
  logic [31:0] data_size;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic predict_reset();
    hdr_pos      = '0;
    hdr_phase    = PH_RIFF;
    magic_failed = 1'b0;
    hdr_shift    = '0;
    cur_kind     = KIND_OTHER;
    cur_len      = '0;
    cur_left     = '0;
    cur_pad      = 1'b0;
    cur_fields   = '0;
    cur_bits     = '0;
    fmt_seen     = 1'b0;
    data_seen    = 1'b0;
    fmt_word     = '0;
    fmt_bits     = '0;
    data_start   = '0;
    data_size    = '0;
  endtask

  // A chunk is committed only once its whole body has been seen.
  task automatic commit_chunk();
    if (cur_kind == KIND_FMT) begin
      fmt_word = cur_fields;
      fmt_bits = cur_bits;
      fmt_seen = 1'b1;
    end else if (cur_kind == KIND_DATA) begin
      data_start = cur_fields[31:0];
      data_size  = cur_len;
      data_seen  = 1'b1;
    end
    hdr_phase = cur_pad ? PH_PAD : PH_HEAD;
    cur_left  = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input bit is_last);
    logic [32:0]  p;
    logic [32:0]  off;
    logic [32:0]  start;
    logic [31:0]  sz;
    bit           ok;
    whcp_result_t r;
    p = hdr_pos;
    case (hdr_phase)
      PH_RIFF: begin
        ok = 1'b1;
        if (p < 4) ok = (b == RIFF_TAG[8 * (3 - p[1:0]) +: 8]);
        else if (p >= 8 && p < 12) ok = (b == WAVE_TAG[8 * (3 - p[1:0]) +: 8]);
        if (!ok) begin
          magic_failed = 1'b1;
          hdr_phase    = PH_IDLE;
        end else if (p >= 11) begin
          hdr_phase = PH_HEAD;
          cur_left  = '0;
        end
      end
      PH_HEAD: begin
        hdr_shift = {b, hdr_shift[63:8]};
        cur_left  = cur_left + 33'd1;
        if (cur_left >= 8) begin
          sz         = hdr_shift[63:32];
          start      = p + 33'd1;
          cur_len    = sz;
          cur_fields = '0;
          cur_bits   = '0;
          if (hdr_shift[31:0] == ID_FMT && sz >= FMT_MIN_SIZE) begin
            cur_kind = KIND_FMT;
          end else if (hdr_shift[31:0] == ID_DATA) begin
            cur_kind   = KIND_DATA;
            cur_fields = 64'(start > POS_MAX ? POS_MAX : start);
          end else begin
            cur_kind = KIND_OTHER;
          end
          cur_pad  = sz[0];
          cur_left = {1'b0, sz};
          if (sz == 0) commit_chunk();
          else hdr_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        off = {1'b0, cur_len} - cur_left;
        if (cur_kind == KIND_FMT) begin
          if (off < 8) cur_fields = cur_fields | (64'(b) << (8 * off[2:0]));
          else if (off == 14) cur_bits[7:0] = b;
          else if (off == 15) cur_bits[15:8] = b;
        end
        if (cur_left > 0) cur_left = cur_left - 33'd1;
        if (cur_left == 0) commit_chunk();
      end
      PH_PAD: begin
        hdr_phase = PH_HEAD;
        cur_left  = '0;
      end
      default: ;
    endcase
    hdr_pos = (p < POS_CAP) ? p + 33'd1 : POS_CAP;
    if (is_last) begin
      if (magic_failed || hdr_phase == PH_RIFF) r.status = STATUS_NOT_WAVE;
      else if (!fmt_seen || !data_seen) r.status = STATUS_MISSING;
      else if (fmt_word[15:0] != FORMAT_PCM) r.status = STATUS_NOT_PCM;
      else r.status = STATUS_OK;
      r.format_code  = fmt_word[15:0];
      r.channels     = fmt_word[31:16];
      r.rate_hz      = fmt_word[63:32];
      r.sample_width = fmt_bits;
      r.data_offset  = data_start;
      r.data_length  = data_size;
      expected_headers.push_back(r);
      predict_reset();
    end
  endtask

  // Offers one byte; returns at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_file();
    src_idle  = idle_on && $urandom_range(0, 2) != 0;
    sink_idle = idle_on && $urandom_range(0, 2) != 0;
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // Stops offering and waits for every outstanding report.
  task automatic wait_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (expected_headers.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (expected_headers.size() != 0) begin
      $error("reports still missing: %0d", expected_headers.size());
      error_count++;
    end
  endtask

  task automatic push_le16(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endtask

  task automatic push_le32(input logic [31:0] v);
    push_le16(v[15:0]);
    push_le16(v[31:16]);
  endtask

  task automatic push_riff_head();
    for (int i = 3; i >= 0; i--) file_bytes.push_back(RIFF_TAG[8 * i +: 8]);
    push_le32($urandom);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(WAVE_TAG[8 * i +: 8]);
  endtask

  task automatic add_chunk(input logic [31:0] id, input logic [31:0] sz, input int body_len);
    push_le32(id);
    push_le32(sz);
    repeat (body_len) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_fmt(input logic [31:0] sz, input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits);
    push_le32(ID_FMT);
    push_le32(sz);
    push_le16(code);
    push_le16(ch);
    push_le32(rate);
    push_le32($urandom);
    push_le16(16'($urandom));
    push_le16(bits);
    repeat (sz - 16) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_pad(input logic [31:0] sz);
    if (sz[0]) file_bytes.push_back(8'($urandom));
  endtask

  // Mostly well-formed files with random chunk lists; some noise, corrupted magic and broken endings.
  task automatic build_random_file();
    int          sel;
    int          nchunks;
    logic [31:0] sz;
    logic [31:0] id;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
      return;
    end
    push_riff_head();
    if (sel < 16) file_bytes[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
    nchunks = $urandom_range(0, 4);
    for (int i = 0; i < nchunks; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 4) == 0) begin
            sz = $urandom_range(0, 15);
            add_chunk(ID_FMT, sz, sz);
          end else begin
            sz = $urandom_range(16, 21);
            add_fmt(sz, $urandom_range(0, 3) != 0 ? FORMAT_PCM : 16'($urandom),
                    16'($urandom), $urandom, 16'($urandom));
          end
        end
        4, 5, 6: begin
          sz = $urandom_range(0, 12);
          add_chunk(ID_DATA, sz, sz);
        end
        default: begin
          id = $urandom_range(0, 1) ? $urandom : ID_DATA ^ (32'd1 << $urandom_range(0, 31));
          sz = $urandom_range(0, 10);
          add_chunk(id, sz, sz);
        end
      endcase
      // An odd chunk at the very end sometimes goes without its pad byte.
      if (!(i == nchunks - 1 && $urandom_range(0, 3) == 0)) add_pad(sz);
    end
    case ($urandom_range(0, 9))
      0: begin
        sz = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(20, 60));
        add_chunk($urandom_range(0, 1) ? ID_FMT : ID_DATA, sz, $urandom_range(0, 19));
      end
      1: repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic test_magic();
    file_bytes.push_back(RIFF_TAG[31:24]);
    send_file();
    push_riff_head();
    void'(file_bytes.pop_back());
    send_file();
    repeat (12) file_bytes.push_back(8'hFF);
    add_fmt(16, FORMAT_PCM, 16'd2, 32'd48000, 16'd16);
    add_chunk(ID_DATA, 4, 4);
    send_file();
    push_riff_head();
    file_bytes[11] = 8'h00;
    add_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(ID_DATA, 2, 2);
    send_file();
    push_riff_head();
    send_file();
  endtask

  task automatic test_chunks();
    // Extreme field values, odd data chunk followed by its pad byte.
    push_riff_head();
    add_fmt(16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_chunk(ID_DATA, 3, 3);
    add_pad(3);
    send_file();
    // Empty data, padded unknown chunk, longer fmt that is not PCM.
    push_riff_head();
    add_chunk(ID_DATA, 0, 0);
    add_chunk($urandom, 5, 5);
    add_pad(5);
    add_fmt(18, 16'hFFFE, 16'd0, 32'd0, 16'd0);
    send_file();
    // A fmt chunk under 16 bytes does not count.
    push_riff_head();
    add_chunk(ID_FMT, 15, 15);
    add_pad(15);
    add_chunk(ID_DATA, 2, 2);
    send_file();
    // The later fmt wins; the file ends right after an odd body.
    push_riff_head();
    add_fmt(16, 16'd0, 16'd3, 32'd1, 16'd24);
    add_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
    add_chunk(ID_DATA, 1, 1);
    send_file();
    // A truncated data chunk leaves the earlier one in place.
    push_riff_head();
    add_fmt(16, FORMAT_PCM, 16'd1, 32'd22050, 16'd8);
    add_chunk(ID_DATA, 4, 4);
    add_chunk(ID_DATA, 100, 10);
    send_file();
    // A chunk header cut short by the end of the file.
    push_riff_head();
    add_fmt(16, FORMAT_PCM, 16'd6, 32'd96000, 16'd32);
    add_chunk(ID_DATA, 2, 2);
    repeat (5) file_bytes.push_back(8'($urandom));
    send_file();
  endtask

  // The receiver holds off long enough that the parser stalls on a final byte.
  task automatic test_backpressure();
    fork
      begin
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    repeat (8) begin
      build_random_file();
      send_file();
    end
    wait_drained();
  endtask

  task automatic test_random();
    idle_on = 1'b1;
    while (bytes_sent < 1600) begin
      if (bytes_sent >= 1400) idle_on = 1'b0;
      build_random_file();
      send_file();
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    idle_on = 1'b0;
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Outputs are stable at the falling edge; a request seen here completes at the next rise.
  always @(negedge clk) begin
    whcp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_headers.size() == 0) begin
        $error("report with no file pending");
        error_count++;
      end else begin
        want = expected_headers.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("format_code", 32'(want.format_code), 32'(out_tdata[15:0]));
        check_field("channels", 32'(want.channels), 32'(out_tdata[31:16]));
        check_field("rate_hz", want.rate_hz, out_tdata[63:32]);
        check_field("sample_width", 32'(want.sample_width), 32'(out_tdata[79:64]));
        check_field("data_offset", want.data_offset, out_tdata[111:80]);
        check_field("data_length", want.data_length, out_tdata[143:112]);
      end
    end
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    predict_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_magic();
    test_chunks();
    wait_drained();
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk);
    if (expected_headers.size() != 0) begin
      $error("%0d reports never arrived", expected_headers.size());
      error_count++;
    end
    if (error_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/whcp_pkg.sv
rtl/core/whcp_in_reg.sv
rtl/core/whcp_parse.sv
rtl/core/whcp_out_reg.sv
rtl/core/wav_header_chunk_parser.sv
tb/tb_top.sv
